// ----- sv/bounded_favourite_set_toggle_defines.svh -----
// Assertion macros shared by the favourite set RTL.
`ifndef BOUNDED_FAVOURITE_SET_TOGGLE_DEFINES_SVH
`define BOUNDED_FAVOURITE_SET_TOGGLE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check prop at every rising clk edge outside reset.
`define BFST_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that cond never holds outside reset.
`define BFST_ASSERT_NEVER(name, clk, rst, cond, msg) \
   `BFST_ASSERT(name, clk, rst, !(cond), msg)

`else

`define BFST_ASSERT(name, clk, rst, prop, msg)
`define BFST_ASSERT_NEVER(name, clk, rst, cond, msg)

`endif

`endif

// ----- sv/bfst_pkg.sv -----
`timescale 1ns / 1ps

package bfst_pkg;

   localparam int ID_W        = 10;
   localparam int SLOT_W      = 4;
   localparam int STATUS_W    = 3;
   localparam int COUNT_OUT_W = 4;

   typedef enum logic {
      KIND_TOGGLE = 1'b0,
      KIND_READ   = 1'b1
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED   = 3'd0,
      ST_REMOVED = 3'd1,
      ST_FULL    = 3'd2,
      ST_READ_OK = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'd0,
      S_REDUCE = 3'd1,
      S_FOLD   = 3'd2,
      S_MATCH  = 3'd3,
      S_UPDATE = 3'd4
   } state_type;

   // Broadcast commands to every list cell.
   typedef struct packed {
      logic compare;
      logic remove;
      logic append;
   } cell_ctl_type;

endpackage

// ----- sv/bfst_req_if.sv -----
`timescale 1ns / 1ps

interface bfst_req_if import bfst_pkg::*;;
   logic                valid;
   logic                ready;
   kind_type            kind;
   logic [ID_W-1:0]     item_id;
   logic [SLOT_W-1:0]   slot;

   modport source (output valid, output kind, output item_id, output slot, input ready);
   modport sink   (input valid, input kind, input item_id, input slot, output ready);
endinterface

// ----- sv/bfst_rsp_if.sv -----
`timescale 1ns / 1ps

interface bfst_rsp_if import bfst_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [ID_W-1:0]        entry_value;
   logic [COUNT_OUT_W-1:0] entry_count;

   modport source (output valid, output status, output entry_value, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input entry_value, input entry_count,
                   output ready);
endinterface

// ----- sv/bfst_cell.sv -----
`timescale 1ns / 1ps

// One list position: holds an identifier, compares it against the probe and
// takes its right neighbour's value when an entry at or left of it is removed.
module bfst_cell import bfst_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctl_type      ctl,
   input  logic [ID_W-1:0]   probe_id,
   input  logic              occupied,
   input  logic              tail,
   input  logic              hit_in,
   output logic              hit_out,
   input  logic [ID_W-1:0]   next_value,
   output logic [ID_W-1:0]   value,
   output logic              match
);

   logic [ID_W-1:0] value_ff;
   logic            match_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else if (ctl.compare) begin
         match_ff <= occupied && (value_ff == probe_id);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.remove && (hit_in || match_ff)) begin
         value_ff <= next_value;
      end else if (ctl.append && tail) begin
         value_ff <= probe_id;
      end
   end

   assign hit_out = hit_in || match_ff;
   assign value   = value_ff;
   assign match   = match_ff;

endmodule

// ----- sv/bounded_favourite_set_toggle.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Transfer when        Payload
// req_chan  in         valid && ready       kind, item_id, slot
// rsp_chan  out        valid && ready       status, entry_value, entry_count
//
// Each item passes accept, cell compare and commit in turn. A toggle also
// passes the reduce and fold states when ITEM_COUNT is below 1024: a reciprocal
// multiply for the quotient of item_id by ITEM_COUNT, then a multiply-subtract
// for the remainder. Reset empties the list at once: membership is the cell
// compare, so there is no clearing pass. A held result stalls the commit, and
// no new request is taken until the commit is done.
`include "bounded_favourite_set_toggle_defines.svh"

module bounded_favourite_set_toggle import bfst_pkg::*; #(
   parameter int LIST_CAPACITY = 10,
   parameter int ITEM_COUNT    = 1024
) (
   input logic         clock,
   input logic         reset,
   bfst_req_if.sink    req_chan,
   bfst_rsp_if.source  rsp_chan
);

   localparam int  CNT_W       = $clog2(LIST_CAPACITY + 1);
   localparam int  IDX_W       = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
   localparam int  EXT_W       = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
   localparam bit  NEED_REDUCE = ITEM_COUNT < (1 << ID_W);
   // Reciprocal of ITEM_COUNT, exact for every ID_W-bit dividend; never above 2049.
   localparam int     RED_S   = ID_W + $clog2(ITEM_COUNT);
   localparam longint RED_R   = ((longint'(1) << RED_S) + longint'(ITEM_COUNT) - 1)
                                / longint'(ITEM_COUNT);
   localparam int     RECIP_W = ID_W + 2;
   localparam int     PROD_W  = ID_W + RECIP_W;

   state_type              state_ff, state_in;
   kind_type               kind_ff;
   logic [SLOT_W-1:0]      slot_ff;
   logic [ID_W-1:0]        id_ff, id_in;
   logic [ID_W-1:0]        quot_ff, quot_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [ID_W-1:0]        rsp_value_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;

   cell_ctl_type           ctl;
   logic                   load_rsp;
   status_type             status_sel;
   logic [ID_W-1:0]        value_sel;
   logic                   req_take;

   logic [ID_W-1:0]          cell_value [LIST_CAPACITY];
   logic [LIST_CAPACITY-1:0] cell_match;
   logic [LIST_CAPACITY:0]   hit;

   logic [EXT_W-1:0]       slot_ext;
   logic                   slot_hit;
   logic [ID_W-1:0]        read_value;

   logic [PROD_W-1:0]      recip_prod;
   logic [ID_W-1:0]        recip_quot;
   logic [ID_W-1:0]        fold_sub;

   // Row of list cells; removal hit ripples rightwards, values shift leftwards.
   assign hit[0] = 1'b0;

   for (genvar i = 0; i < LIST_CAPACITY; i++) begin : g_cell
      logic [ID_W-1:0] right_value;

      if (i == LIST_CAPACITY - 1) begin : g_last
         assign right_value = id_ff;
      end else begin : g_inner
         assign right_value = cell_value[i + 1];
      end

      bfst_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .probe_id   (id_ff),
         .occupied   (CNT_W'(i) < count_ff),
         .tail       (CNT_W'(i) == count_ff),
         .hit_in     (hit[i]),
         .hit_out    (hit[i + 1]),
         .next_value (right_value),
         .value      (cell_value[i]),
         .match      (cell_match[i])
      );
   end

   // Read port: slot is in range exactly when it lies below the count.
   assign slot_ext   = EXT_W'(slot_ff);
   assign slot_hit   = slot_ext < EXT_W'(count_ff);
   assign read_value = cell_value[slot_ext[IDX_W-1:0]];

   // Quotient of id by ITEM_COUNT through the reciprocal, then the remainder.
   // The remainder fits ID_W bits, so the product is only needed modulo 2**ID_W.
   assign recip_prod = PROD_W'(id_ff) * PROD_W'(RED_R);
   assign recip_quot = ID_W'(recip_prod >> RED_S);
   assign fold_sub   = quot_ff * ID_W'(ITEM_COUNT);

   assign req_take = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      quot_ff <= quot_in;
      if (req_take) begin
         kind_ff <= req_chan.kind;
         slot_ff <= req_chan.slot;
      end
   end

   always_comb begin
      state_in   = state_ff;
      id_in      = id_ff;
      quot_in    = quot_ff;
      count_in   = count_ff;
      ctl        = '0;
      load_rsp   = 1'b0;
      status_sel = ST_EMPTY;
      value_sel  = '0;
      req_chan.ready = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               id_in = req_chan.item_id;
               if (NEED_REDUCE && req_chan.kind == KIND_TOGGLE) begin
                  state_in = S_REDUCE;
               end else begin
                  state_in = S_MATCH;
               end
            end
         end
         S_REDUCE: begin
            // Hold the quotient for the fold.
            quot_in  = recip_quot;
            state_in = S_FOLD;
         end
         S_FOLD: begin
            id_in    = id_ff - fold_sub;
            state_in = S_MATCH;
         end
         S_MATCH: begin
            // Latch each cell's compare against the probe.
            ctl.compare = 1'b1;
            state_in    = S_UPDATE;
         end
         S_UPDATE: begin
            // Hold the commit while the previous result is still waiting.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
               if (kind_ff == KIND_READ) begin
                  if (slot_hit) begin
                     status_sel = ST_READ_OK;
                     value_sel  = read_value;
                  end else begin
                     status_sel = ST_EMPTY;
                  end
               end else if (hit[LIST_CAPACITY]) begin
                  // Present: drop it and close the gap.
                  status_sel = ST_REMOVED;
                  ctl.remove = 1'b1;
                  count_in   = count_ff - 1'b1;
               end else if (count_ff == CNT_W'(LIST_CAPACITY)) begin
                  // Absent but no room: refuse, leave the list alone.
                  status_sel = ST_FULL;
               end else begin
                  // Absent: append at the tail.
                  status_sel = ST_ADDED;
                  ctl.append = 1'b1;
                  count_in   = count_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result register: one transfer per item, parts the two sides.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= status_sel;
         rsp_value_ff  <= value_sel;
         rsp_count_ff  <= COUNT_OUT_W'(count_in);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.entry_value = rsp_value_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

   `BFST_ASSERT(a_busy_after_take, clock, reset,
                req_take |=> !req_chan.ready, "request taken while busy")
   `BFST_ASSERT_NEVER(a_count_bound, clock, reset,
                      count_ff > CNT_W'(LIST_CAPACITY), "list count above capacity")
   `BFST_ASSERT(a_full_at_capacity, clock, reset,
                (rsp_valid_ff && rsp_status_ff == ST_FULL) |->
                (rsp_count_ff == COUNT_OUT_W'(LIST_CAPACITY)), "full refusal below capacity")
   `BFST_ASSERT(a_unique_entries, clock, reset,
                (state_ff == S_UPDATE) |-> ($countones(cell_match) <= 1),
                "identifier held twice in the list")

endmodule
